// ----- sv/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the 2x2 box-filter downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  localparam int LW_W = 12;
  localparam int FH_W = 13;
  // compare width for the clamped line width
  localparam int WW   = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;

  localparam logic [LW_W-1:0] LW_RESET = LW_W'(512);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(512);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] average;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

endpackage

// ----- sv/bds_line_store.sv -----
// ----------------------------------------------------------------------------
// bds_line_store
// Line store of horizontal pair sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module bds_line_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [bds_pkg::ADDR_W-1:0] wr_addr,
  input  logic [8:0]                wr_data,
  input  logic                      rd_en,
  input  logic [bds_pkg::ADDR_W-1:0] rd_addr,
  output logic [8:0]                rd_data
);

  logic [8:0] mem [bds_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/box_downsample_2x2.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-filter decimation of an 8-bit grey plane in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel word per accepted cycle (valid high, stall low), with
//           frame_start marking the first pixel of a frame.
//   out_* : one word per complete 2x2 block, issued on the block's
//           bottom-right pixel; row_end / frame_end flag the last block of
//           an output row / of the frame.
//   cfg_* : APB-style registers, line_width at 0x0, frame_height at 0x4;
//           write only while the block is idle.
// Throughput: one pixel per cycle while in_stall is low. A result passes
//   through the line-store read register, then the output register.
// Reset (rst_n low, synchronous): counters, held pixel and valid flags
//   clear; the registers return to 512 x 512. The line store is not
//   cleared; every entry is written on an even row before the odd row reads.
// Stall: a stalled output word holds; the pipeline keeps accepting until
//   its one internal stage is full, then in_stall follows out_stall.
// ----------------------------------------------------------------------------
module box_downsample_2x2 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bds_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bds_pkg::out_word_t           out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bds_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [bds_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [bds_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int COL_W  = bds_pkg::COL_W;
  localparam int ROW_W  = bds_pkg::ROW_W;
  localparam int ADDR_W = bds_pkg::ADDR_W;
  localparam int WW     = bds_pkg::WW;
  localparam int FH_W   = bds_pkg::FH_W;
  localparam int LW_W   = bds_pkg::LW_W;

  // configuration
  logic [LW_W-1:0] line_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            cfg_wr;
  bds_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = bds_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= bds_pkg::LW_RESET;
      frame_height_r <= bds_pkg::FH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bds_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_pwdata[LW_W-1:0];
        bds_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bds_pkg::REG_LINE_WIDTH:   cfg_prdata = bds_pkg::PDATA_W'(line_width_r);
      bds_pkg::REG_FRAME_HEIGHT: cfg_prdata = bds_pkg::PDATA_W'(frame_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // clamped geometry
  logic [WW-1:0]   lw_ext, w_eff, last_col;
  logic [FH_W-1:0] h_eff, last_row;

  always_comb begin
    lw_ext = WW'(line_width_r);
    if (lw_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (lw_ext > WW'(bds_pkg::MAX_WIDTH)) begin
      w_eff = WW'(bds_pkg::MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    if (frame_height_r < FH_W'(2)) begin
      h_eff = FH_W'(2);
    end else if (frame_height_r > FH_W'(bds_pkg::MAX_HEIGHT)) begin
      h_eff = FH_W'(bds_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
    last_col = {w_eff[WW-1:1], 1'b0} - WW'(1);
    last_row = {h_eff[FH_W-1:1], 1'b0} - FH_W'(1);
  end

  // handshake
  logic s1_valid_r, out_valid_r, s1_move, in_acc;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  // position and per-pixel decode
  logic [COL_W-1:0] column_count_r, column_count_nxt, x;
  logic [ROW_W-1:0] row_count_r, row_count_nxt, y;
  logic [7:0]       held_pixel_r;
  logic [8:0]       pair;
  logic             in_block, do_write, do_emit, rend, fend;

  always_comb begin
    x = in_data.frame_start ? '0 : column_count_r;
    y = in_data.frame_start ? '0 : row_count_r;
    pair     = {1'b0, held_pixel_r} + {1'b0, in_data.pixel};
    in_block = x[0] && (WW'(x) <= last_col) && (FH_W'(y) <= last_row);
    do_write = in_acc && in_block && !y[0];
    do_emit  = in_acc && in_block && y[0];
    rend     = (WW'(x) == last_col);
    fend     = rend && (FH_W'(y) == last_row);
    if (WW'(x) + WW'(1) >= w_eff) begin
      column_count_nxt = '0;
      if (FH_W'(y) + FH_W'(1) >= h_eff) begin
        row_count_nxt = '0;
      end else begin
        row_count_nxt = y + ROW_W'(1);
      end
    end else begin
      column_count_nxt = x + COL_W'(1);
      row_count_nxt    = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
      held_pixel_r   <= '0;
    end else if (in_acc) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      if (!x[0]) begin
        held_pixel_r <= in_data.pixel;
      end
    end
  end

  logic [8:0] stored_sum;

  bds_line_store u_line_store (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (x[ADDR_W:1]),
    .wr_data (pair),
    .rd_en   (do_emit),
    .rd_addr (x[ADDR_W:1]),
    .rd_data (stored_sum)
  );

  // stage 1: current pair sum alongside the line-store read
  logic [8:0] s1_pair_r;
  logic       s1_rend_r, s1_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc || s1_move) begin
      s1_valid_r <= do_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      s1_pair_r <= pair;
      s1_rend_r <= rend;
      s1_fend_r <= fend;
    end
  end

  // output register
  logic [9:0]         block_sum;
  bds_pkg::out_word_t out_data_r;

  assign block_sum = {1'b0, stored_sum} + {1'b0, s1_pair_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.average   <= block_sum[9:2];
      out_data_r.row_end   <= s1_rend_r;
      out_data_r.frame_end <= s1_fend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/bds_checker.sv -----
// ----------------------------------------------------------------------------
// bds_checker
// Port-level checks for box_downsample_2x2, bound to the top level.
// ----------------------------------------------------------------------------
module bds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bds_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_frame_has_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.row_end)
    else $error("frame_end without row_end");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output word without a matching accepted pixel");

endmodule

bind box_downsample_2x2 bds_checker u_bds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
